FILE: sv/nmsc_pkg.sv
// Shared types, constants and helper functions for the NMEA sentence
// checker/classifier. No dependencies; imported by every other file but nmsc_if.
package nmsc_pkg;

  localparam int TAG_COUNT = 7;
  localparam int TAG_LEN   = 6;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  // Result codes
  localparam logic [2:0] KIND_GENERIC = 3'd7;
  localparam logic [3:0] MSG_ERROR    = 4'd8;

  // Sentence tags, in priority order: GSV, RMC, VTG, GGA, GSA, GLL, GBS
  localparam logic [7:0] TAG_CHARS [TAG_COUNT][TAG_LEN] = '{
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h56},
    '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
    '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47},
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h53, 8'h41},
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h4C, 8'h4C},
    '{8'h24, 8'h47, 8'h50, 8'h47, 8'h42, 8'h53}
  };

  // Progress through the first comma-delimited field
  typedef struct packed {
    logic [2:0]           pos;
    logic [TAG_COUNT-1:0] cand;
    logic                 closed;
    logic [2:0]           kind;
  } tag_state_t;

  localparam tag_state_t TAG_STATE_CLEAR = '{
    pos:    3'd0,
    cand:   {TAG_COUNT{1'b1}},
    closed: 1'b0,
    kind:   KIND_GENERIC
  };

  // Input register contents handed to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       som;
  } stage_t;

  // Uppercase hex character of the low nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
    logic [7:0] ext;
    ext = {4'd0, nibble};
    if (nibble < 4'd10) begin
      return 8'h30 + ext;
    end else begin
      return 8'h41 + ext - 8'd10;
    end
  endfunction

endpackage

FILE: sv/nmsc_if.sv
// Valid/ready channel interfaces for the NMEA sentence checker/classifier.
// Depends on nothing; listed after nmsc_pkg.
interface nmsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_message;

  modport source (output valid, data_byte, start_of_message, input ready);
  modport sink   (input valid, data_byte, start_of_message, output ready);
endinterface

interface nmsc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] message_type;
  logic [7:0] computed_checksum;

  modport source (output valid, message_type, computed_checksum, input ready);
  modport sink   (input valid, message_type, computed_checksum, output ready);
endinterface

FILE: sv/nmsc_tag_match.sv
// Next-state logic for matching the first field against the tag table.
// Depends on nmsc_pkg.
module nmsc_tag_match (
  input  nmsc_pkg::tag_state_t cur,
  input  logic [7:0]           data,
  output nmsc_pkg::tag_state_t nxt
);
  import nmsc_pkg::*;

  always_comb begin
    nxt = cur;
    if (!cur.closed) begin
      if (data == CHAR_COMMA) begin
        // Close the field; lowest-numbered surviving tag wins
        nxt.closed = 1'b1;
        nxt.kind   = KIND_GENERIC;
        if (cur.pos == 3'(TAG_LEN)) begin
          for (int k = TAG_COUNT - 1; k >= 0; k--) begin
            if (cur.cand[k]) begin
              nxt.kind = 3'(k);
            end
          end
        end
      end else if (cur.pos < 3'(TAG_LEN)) begin
        for (int k = 0; k < TAG_COUNT; k++) begin
          if (TAG_CHARS[k][cur.pos] != data) begin
            nxt.cand[k] = 1'b0;
          end
        end
        nxt.pos = cur.pos + 3'd1;
      end else begin
        // Field too long: nothing can match
        nxt.cand = '0;
      end
    end
  end

endmodule

FILE: sv/nmsc_parser.sv
// Sentence state machine, checksum accumulation and result register.
// Depends on nmsc_pkg, nmsc_if and nmsc_tag_match.
module nmsc_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nmsc_pkg::stage_t     stage,
  input  logic                 adv,
  nmsc_out_if.source           out_ch
);
  import nmsc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BODY  = 2'd1,
    PH_HEX_1 = 2'd2,
    PH_HEX_2 = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] xor_r, xor_nxt;
  tag_state_t tag_r, tag_nxt;
  logic [7:0] fhc_r, fhc_nxt;
  logic       out_valid_r;
  logic [3:0] out_type_r, out_type_nxt;
  logic [7:0] out_sum_r;
  logic       emit;

  tag_state_t tag_in;
  tag_state_t tag_step;

  assign tag_in = stage.som ? TAG_STATE_CLEAR : tag_r;

  nmsc_tag_match u_tag_match (
    .cur  (tag_in),
    .data (stage.data),
    .nxt  (tag_step)
  );

  always_comb begin
    phase_nxt    = phase_r;
    xor_nxt      = xor_r;
    tag_nxt      = tag_r;
    fhc_nxt      = fhc_r;
    emit         = 1'b0;
    out_type_nxt = MSG_ERROR;
    if (stage.som) begin
      // Drop any unfinished sentence and restart
      xor_nxt = 8'd0;
      fhc_nxt = 8'd0;
      if (stage.data == CHAR_NUL) begin
        phase_nxt = PH_IDLE;
        tag_nxt   = TAG_STATE_CLEAR;
      end else begin
        phase_nxt = PH_BODY;
        tag_nxt   = tag_step;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_BODY: begin
          priority if (stage.data == CHAR_NUL) begin
            phase_nxt = PH_IDLE;
            xor_nxt   = 8'd0;
            tag_nxt   = TAG_STATE_CLEAR;
            fhc_nxt   = 8'd0;
          end else if (stage.data == CHAR_STAR) begin
            if (!tag_r.closed) begin
              tag_nxt.closed = 1'b1;
              tag_nxt.kind   = KIND_GENERIC;
            end
            phase_nxt = PH_HEX_1;
          end else begin
            xor_nxt = xor_r ^ stage.data;
            tag_nxt = tag_step;
          end
        end
        PH_HEX_1: begin
          fhc_nxt   = stage.data;
          phase_nxt = PH_HEX_2;
        end
        PH_HEX_2: begin
          emit      = 1'b1;
          phase_nxt = PH_IDLE;
          if (fhc_r == hex_digit(xor_r[7:4]) && stage.data == hex_digit(xor_r[3:0])) begin
            out_type_nxt = {1'b0, tag_r.kind};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State and result register; the result payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      xor_r       <= 8'd0;
      tag_r       <= TAG_STATE_CLEAR;
      fhc_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        phase_r <= phase_nxt;
        xor_r   <= xor_nxt;
        tag_r   <= tag_nxt;
        fhc_r   <= fhc_nxt;
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
        out_type_r  <= out_type_nxt;
        out_sum_r   <= xor_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.message_type      = out_type_r;
  assign out_ch.computed_checksum = out_sum_r;

endmodule

FILE: sv/nmsc_sentence_check_classify_top.sv
// Top level of the NMEA sentence checker/classifier: input register and parser.
// Depends on nmsc_pkg, nmsc_if, nmsc_tag_match and nmsc_parser.
//
// Usage:
//   in_ch  carries one sentence byte per transaction (data_byte) with
//          start_of_message set on the first byte of each sentence.
//   out_ch carries one transaction per sentence whose two checksum digits
//          have arrived: message_type (0 GSV .. 6 GBS, 7 generic,
//          8 checksum error) and the XOR of the bytes between the first
//          byte and the '*' (computed_checksum).
//   Throughput: one byte per clock. Each byte passes an input register and
//   the parsing logic (XOR, tag compare, hex compare), so a new byte is
//   accepted in every cycle while the result side keeps up.
//   Results: the second checksum digit passes the input register, then
//   the parser's result register presents the result for the sentence.
//   Stalls: a result held by a low out_ch.ready freezes the parser; the
//   input register still takes one more byte, then in_ch.ready drops until
//   the result is taken. Nothing is lost or repeated.
//   Reset (rst_n low, synchronous): drop the input register and any pending
//   result, return the parser to idle awaiting a start byte.
//   Sentences lacking '*', or containing a NUL before it, give no result.
module nmea_sentence_check_classify (
  input  logic        clk,
  input  logic        rst_n,
  nmsc_in_if.sink     in_ch,
  nmsc_out_if.source  out_ch
);
  import nmsc_pkg::*;

  stage_t stage_r;
  logic   adv;

  // Advance the held byte into the parser unless a result is stuck
  assign adv         = stage_r.valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !stage_r.valid || adv;

  // Input register; the byte payload needs no reset and holds while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      stage_r.valid <= 1'b1;
    end else if (adv) begin
      stage_r.valid <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      stage_r.data <= in_ch.data_byte;
      stage_r.som  <= in_ch.start_of_message;
    end
  end

  nmsc_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage_r),
    .adv    (adv),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  // Back-pressure reaches the input only through a held byte and a stuck result
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (stage_r.valid && out_ch.valid && !out_ch.ready))
    else $error("in_ch.ready low without a stalled result");

  // A new result needs a byte to have been consumed at the previous edge
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(stage_r.valid))
    else $error("result appeared without a consumed byte");

  // Result codes stay in range
  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.message_type <= MSG_ERROR))
    else $error("message_type out of range");
`endif

endmodule
